/* rtl/afs_pkg.sv */
// Shared types and constants for the animation frame sequencer.
package afs_pkg;

    localparam int FRAME_W   = 8;
    localparam int REPEAT_W  = 8;
    localparam int PERIOD_W  = 10;
    localparam int ELAPSED_W = 11;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 10;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK      = 3'd0,
        KIND_PLAY      = 3'd1,
        KIND_STOP      = 3'd2,
        KIND_GOTO_PLAY = 3'd3,
        KIND_GOTO_STOP = 3'd4
    } afs_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT  = 2'd0,
        REG_FIRST_FRAME  = 2'd1,
        REG_LAST_FRAME   = 2'd2,
        REG_FRAME_PERIOD = 2'd3
    } afs_reg_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_count;
        logic [FRAME_W-1:0]  first_frame;
        logic [FRAME_W-1:0]  last_frame;
        logic [PERIOD_W-1:0] frame_period;
    } afs_cfg_t;

    typedef struct packed {
        logic [REPEAT_W-1:0] repeats_remaining;
        logic                frame_changed;
        logic                is_playing;
        logic [FRAME_W-1:0]  frame_index;
    } afs_result_t;

endpackage

/* rtl/afs_cfg_regs.sv */
// Configuration register file for the animation frame sequencer.
module afs_cfg_regs
    import afs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output afs_cfg_t             cfg
);

    afs_cfg_t cfg_reg;
    afs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_COUNT:  cfg_next.frame_count  = cfg_data[FRAME_W-1:0];
                REG_FIRST_FRAME:  cfg_next.first_frame  = cfg_data[FRAME_W-1:0];
                REG_LAST_FRAME:   cfg_next.last_frame   = cfg_data[FRAME_W-1:0];
                REG_FRAME_PERIOD: cfg_next.frame_period = cfg_data[PERIOD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count  <= FRAME_W'(1);
            cfg_reg.first_frame  <= '0;
            cfg_reg.last_frame   <= '0;
            cfg_reg.frame_period <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/afs_core.sv */
// Input register, player state and single-pass update logic.
module afs_core
    import afs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  afs_cfg_t             cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KIND_W-1:0]    in_kind,
    input  logic [FRAME_W-1:0]   in_target,
    input  logic [REPEAT_W-1:0]  in_request,
    input  logic                 res_ready,
    output logic                 res_valid,
    output afs_result_t          res
);

    logic                 valid_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [FRAME_W-1:0]   target_reg;
    logic [REPEAT_W-1:0]  request_reg;

    logic [FRAME_W-1:0]   cur_reg, cur_next;
    logic                 run_reg, run_next;
    logic [REPEAT_W-1:0]  rep_reg, rep_next;
    logic [ELAPSED_W-1:0] el_reg, el_next;

    logic                 process;
    logic                 period_nz;
    logic                 target_ok;
    logic                 first_ok;
    logic                 step_ok;
    logic [ELAPSED_W-1:0] el_inc;
    logic [ELAPSED_W-1:0] period_ext;

    assign process  = valid_reg && res_ready;
    assign in_ready = !valid_reg || res_ready;

    assign period_nz  = cfg.frame_period != '0;
    assign period_ext = {1'b0, cfg.frame_period};
    assign target_ok  = target_reg < cfg.frame_count;
    assign first_ok   = cfg.first_frame < cfg.frame_count;
    assign step_ok    = ({1'b0, cur_reg} + 9'd1) < {1'b0, cfg.frame_count};
    assign el_inc     = (el_reg == ELAPSED_MAX) ? el_reg : el_reg + ELAPSED_W'(1);

    always_comb
    begin
        cur_next = cur_reg;
        run_next = run_reg;
        rep_next = rep_reg;
        el_next  = el_reg;
        case (kind_reg)
            KIND_TICK:
            begin
                if (run_reg)
                begin
                    el_next = el_inc;
                    if (el_inc > period_ext)
                    begin
                        if (cur_reg < cfg.last_frame)
                        begin
                            if (step_ok)
                                cur_next = cur_reg + FRAME_W'(1);
                            el_next = el_inc - period_ext;
                        end
                        else if (first_ok)
                        begin
                            cur_next = cfg.first_frame;
                            el_next  = '0;
                            if (rep_reg == REPEAT_W'(1))
                                run_next = 1'b0;
                            else
                            begin
                                run_next = period_nz;
                                if (rep_reg > REPEAT_W'(1))
                                    rep_next = rep_reg - REPEAT_W'(1);
                            end
                        end
                    end
                end
            end
            KIND_PLAY:
            begin
                rep_next = request_reg;
                if (period_nz)
                    run_next = 1'b1;
            end
            KIND_STOP:
            begin
                if (!period_nz || el_reg >= period_ext)
                    el_next = '0;
                run_next = 1'b0;
            end
            KIND_GOTO_PLAY:
            begin
                if (target_ok)
                begin
                    cur_next = target_reg;
                    el_next  = '0;
                    run_next = period_nz;
                    rep_next = '0;
                end
            end
            KIND_GOTO_STOP:
            begin
                if (target_ok)
                begin
                    cur_next = target_reg;
                    el_next  = '0;
                    run_next = 1'b0;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cur_reg   <= '0;
            run_reg   <= 1'b0;
            rep_reg   <= '0;
            el_reg    <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (process)
            begin
                cur_reg <= cur_next;
                run_reg <= run_next;
                rep_reg <= rep_next;
                el_reg  <= el_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg    <= in_kind;
            target_reg  <= in_target;
            request_reg <= in_request;
        end
    end

    assign res_valid             = valid_reg;
    assign res.frame_index       = cur_next;
    assign res.is_playing        = run_next;
    assign res.frame_changed     = cur_next != cur_reg;
    assign res.repeats_remaining = rep_next;

`ifndef SYNTHESIS
    // frame index never reaches 255: every source is bounded by frame_count
    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg != '1)
        else $error("current frame out of range");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_ready |=> valid_reg && $stable(kind_reg) && $stable(target_reg))
        else $error("stalled request lost");

    a_state_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(cur_reg) && $stable(run_reg) && $stable(rep_reg)
                     && $stable(el_reg))
        else $error("state moved without a request");

    a_busy_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg)
        else $error("ready dropped while empty");
`endif

endmodule

/* rtl/afs_out_reg.sv */
// Result register towards the master side.
module afs_out_reg
    import afs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    output logic        res_ready,
    input  afs_result_t res,
    output logic        out_valid,
    input  logic        out_ready,
    output afs_result_t out_res
);

    logic        valid_reg;
    afs_result_t res_reg;

    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_ready)
            valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* rtl/animation_frame_sequencer.sv */
// Top level of the animation frame sequencer.
//
// Slave stream: one request per tick or command. tuser carries the kind
// (tick, play, stop, goto and play, goto and stop); tdata carries the goto
// target and the repeat count for play.
// Master stream: one result per request with the frame shown, the playing
// flag, a frame-changed flag and the repeats held.
// Configuration: write frame_count, first_frame, last_frame and
// frame_period through cfg_we/cfg_index/cfg_data while no request is in
// flight.
// tvalid on the master side rises once the result is loaded: the accepting
// edge loads the input register, and the result register is loaded from it
// when it is free. One request is taken every cycle while s_tready is high;
// the state update is a single compare/increment/select pass.
// When the receiver stalls, the result register holds and the input
// register fills, after which s_tready drops until m_tready returns.
// Reset clears the player (frame 0, stopped, no repeats, no elapsed time)
// and loads the register defaults (one frame, period zero).
module animation_frame_sequencer
    import afs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // target_frame[7:0], repeat_request[15:8]
    input  logic [KIND_W-1:0]     s_tuser,  // kind[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // frame_index[7:0], is_playing[8],
                                            // frame_changed[9], repeats_remaining[17:10]
);

    afs_cfg_t    cfg;
    logic        res_valid;
    logic        res_ready;
    afs_result_t res;
    afs_result_t out_res;

    afs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_target  (s_tdata[7:0]),
        .in_request (s_tdata[15:8]),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    afs_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {{(OUT_DATA_W - $bits(afs_result_t)){1'b0}}, out_res};

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for animation_frame_sequencer: directed table, random phases, predictor.
module tb_top;
    import afs_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int RANDOM_PHASES = 18;
    localparam int PHASE_REQUESTS = 55;
    localparam int OVERRUN_TICKS = 40;

    typedef struct {
        logic [FRAME_W-1:0]   frame;
        logic                 playing;
        logic [REPEAT_W-1:0]  repeats;
        logic [ELAPSED_W-1:0] elapsed;
    } player_t;

    typedef struct packed {
        logic                 cfg_row;    // register write instead of a request
        logic [KIND_W-1:0]    kind;
        logic [FRAME_W-1:0]   target;
        logic [REPEAT_W-1:0]  repeats;
        afs_reg_t             reg_index;
        logic [CFG_DAT_W-1:0] reg_value;
        logic                 checked;    // expected result given in the row
        logic [FRAME_W-1:0]   exp_frame;
        logic                 exp_playing;
        logic                 exp_changed;
        logic [REPEAT_W-1:0]  exp_repeats;
    } step_row_t;

    localparam int DIRECTED_ROWS = 32;
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_PLAY, 8'd0, 8'd255, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd255},
        '{1'b0, KIND_GOTO_PLAY, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_GOTO_STOP, 8'd255, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_UNUSED, 8'd255, 8'd255, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_STOP, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd255, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_FIRST_FRAME, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_LAST_FRAME, 10'd254, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_FRAME_PERIOD, 10'd1, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_GOTO_PLAY, 8'd254, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd254, 1'b1, 1'b1, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd254, 1'b1, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b1, 8'd0, 1'b1, 1'b1, 8'd0},
        '{1'b0, KIND_PLAY, 8'd0, 8'd2, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_GOTO_STOP, 8'd253, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_PLAY, 8'd0, 8'd2, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_STOP, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_GOTO_STOP, 8'd254, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_PLAY, 8'd0, 8'd1, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd2, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_GOTO_PLAY, 8'd1, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_FRAME_PERIOD, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b1, KIND_TICK, 8'd0, 8'd0, REG_LAST_FRAME, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0},
        '{1'b0, KIND_TICK, 8'd0, 8'd0, REG_FRAME_COUNT, 10'd0, 1'b0, 8'd0, 1'b0, 1'b0, 8'd0}
    };

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // target_frame[7:0], repeat_request[15:8]
    logic [KIND_W-1:0]     s_tuser   = '0;  // kind[2:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // frame_index[7:0], is_playing[8],
                                            // frame_changed[9], repeats_remaining[17:10]

    afs_cfg_t    settings;
    player_t     player;
    afs_result_t pending_results[$];
    int          mismatches = 0;
    int          send_idle  = 26;
    int          recv_idle  = 78;

    animation_frame_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("FAIL animation_frame_sequencer");
        $finish;
    end

    function automatic logic seek_frame(input logic [FRAME_W-1:0] frame, input logic then_play);
        if (frame >= settings.frame_count)
            return 1'b0;
        player.frame   = frame;
        player.elapsed = '0;
        player.playing = then_play && (settings.frame_period != 0);
        return 1'b1;
    endfunction

    function automatic afs_result_t predict_result(input logic [KIND_W-1:0]   kind,
                                                   input logic [FRAME_W-1:0]  target,
                                                   input logic [REPEAT_W-1:0] repeats);
        logic [FRAME_W-1:0] prior;
        afs_result_t        r;
        prior = player.frame;
        case (kind)
            KIND_TICK:
            begin
                if (player.playing)
                begin
                    if (player.elapsed != ELAPSED_MAX)
                        player.elapsed = player.elapsed + 1'b1;
                    if (player.elapsed > settings.frame_period)
                    begin
                        if (player.frame < settings.last_frame)
                        begin
                            if (int'(player.frame) + 1 < int'(settings.frame_count))
                                player.frame = player.frame + 1'b1;
                            player.elapsed = player.elapsed - settings.frame_period;
                        end
                        else if (player.repeats == 8'd1)
                            void'(seek_frame(settings.first_frame, 1'b0));
                        else if (seek_frame(settings.first_frame, 1'b1) && player.repeats > 8'd1)
                            player.repeats = player.repeats - 1'b1;
                    end
                end
            end
            KIND_PLAY:
            begin
                player.repeats = repeats;
                if (!player.playing && settings.frame_period != 0)
                    player.playing = 1'b1;
            end
            KIND_STOP:
            begin
                if (settings.frame_period == 0 || player.elapsed >= settings.frame_period)
                    player.elapsed = '0;
                player.playing = 1'b0;
            end
            KIND_GOTO_PLAY:
            begin
                if (seek_frame(target, 1'b1))
                    player.repeats = '0;
            end
            KIND_GOTO_STOP:
                void'(seek_frame(target, 1'b0));
            default: ;
        endcase
        r.frame_index       = player.frame;
        r.is_playing        = player.playing;
        r.frame_changed     = (player.frame != prior);
        r.repeats_remaining = player.repeats;
        return r;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0]   kind,
                                input logic [FRAME_W-1:0]  target,
                                input logic [REPEAT_W-1:0] repeats,
                                input logic                use_given,
                                input afs_result_t         given);
        afs_result_t predicted;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {repeats, target};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_result(kind, target, repeats);
        pending_results.push_back(use_given ? given : predicted);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input afs_reg_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_COUNT:  settings.frame_count  = value[FRAME_W-1:0];
            REG_FIRST_FRAME:  settings.first_frame  = value[FRAME_W-1:0];
            REG_LAST_FRAME:   settings.last_frame   = value[FRAME_W-1:0];
            REG_FRAME_PERIOD: settings.frame_period = value[PERIOD_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input int count, input int first, input int last,
                                  input int period);
        wait_for_results();
        write_register(REG_FRAME_COUNT, CFG_DAT_W'(count));
        write_register(REG_FIRST_FRAME, CFG_DAT_W'(first));
        write_register(REG_LAST_FRAME, CFG_DAT_W'(last));
        write_register(REG_FRAME_PERIOD, CFG_DAT_W'(period));
    endtask

    // result checker and receiver backpressure
    initial
    begin
        afs_result_t got;
        afs_result_t want;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(afs_result_t)-1:0];
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.frame_index !== want.frame_index)
                    begin
                        $error("frame_index: expected %0d, got %0d",
                               want.frame_index, got.frame_index);
                        mismatches++;
                    end
                    if (got.is_playing !== want.is_playing)
                    begin
                        $error("is_playing: expected %0d, got %0d",
                               want.is_playing, got.is_playing);
                        mismatches++;
                    end
                    if (got.frame_changed !== want.frame_changed)
                    begin
                        $error("frame_changed: expected %0d, got %0d",
                               want.frame_changed, got.frame_changed);
                        mismatches++;
                    end
                    if (got.repeats_remaining !== want.repeats_remaining)
                    begin
                        $error("repeats_remaining: expected %0d, got %0d",
                               want.repeats_remaining, got.repeats_remaining);
                        mismatches++;
                    end
                    if (m_tdata[OUT_DATA_W-1:$bits(afs_result_t)] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %h",
                               m_tdata[OUT_DATA_W-1:$bits(afs_result_t)]);
                        mismatches++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        afs_result_t typed_result;
        int          mode;
        int          count;
        int          first;
        int          last;
        int          period;
        int          pick;
        logic [KIND_W-1:0]   kind;
        logic [FRAME_W-1:0]  target;
        logic [REPEAT_W-1:0] repeats;

        settings = '{frame_count: 8'd1, first_frame: 8'd0, last_frame: 8'd0, frame_period: '0};
        player   = '{frame: '0, playing: 1'b0, repeats: '0, elapsed: '0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIRECTED[i].cfg_row)
            begin
                wait_for_results();
                write_register(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
            end
            else
            begin
                typed_result.frame_index       = DIRECTED[i].exp_frame;
                typed_result.is_playing        = DIRECTED[i].exp_playing;
                typed_result.frame_changed     = DIRECTED[i].exp_changed;
                typed_result.repeats_remaining = DIRECTED[i].exp_repeats;
                send_request(DIRECTED[i].kind, DIRECTED[i].target, DIRECTED[i].repeats,
                             DIRECTED[i].checked, typed_result);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode = phase * 3 / RANDOM_PHASES;
            send_idle = (mode == 0) ? 26 : (mode == 1) ? 78 : 0;
            recv_idle = (mode == 0) ? 78 : (mode == 1) ? 26 : 0;
            if (phase == 0)
                apply_settings(255, 0, 254, 1);
            else if (phase == 1)
                apply_settings(1, 0, 0, 1000);
            else
            begin
                pick  = $urandom_range(3);
                count = (pick == 0) ? 1 : (pick == 1) ? 255 : $urandom_range(12, 2);
                pick  = $urandom_range(5);
                first = (pick == 0) ? 0 : (pick == 1) ? 254 : (pick == 2) ? $urandom_range(254)
                      : $urandom_range(count - 1);
                pick  = $urandom_range(5);
                if (pick == 0)
                    last = 0;
                else if (pick == 1)
                    last = 254;
                else if (pick == 2)
                    last = $urandom_range(254);
                else if (first < count)
                    last = $urandom_range(count - 1, first);
                else
                    last = $urandom_range(count - 1);
                pick   = $urandom_range(9);
                period = (pick == 0) ? 0 : (pick == 1) ? 1000 : (pick == 2) ? $urandom_range(1000)
                       : $urandom_range(4, 1);
                apply_settings(count, first, last, period);
            end
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                pick = $urandom_range(99);
                if (pick < 68)
                    kind = KIND_TICK;
                else if (pick < 76)
                    kind = KIND_PLAY;
                else if (pick < 82)
                    kind = KIND_STOP;
                else if (pick < 90)
                    kind = KIND_GOTO_PLAY;
                else if (pick < 97)
                    kind = KIND_GOTO_STOP;
                else
                    kind = KIND_W'($urandom_range(7, 5));
                if ($urandom_range(3) == 0)
                    target = FRAME_W'($urandom_range(255));
                else
                    target = FRAME_W'($urandom_range(int'(settings.frame_count) - 1));
                repeats = ($urandom_range(3) == 0) ? REPEAT_W'($urandom_range(255))
                                                   : REPEAT_W'($urandom_range(3));
                send_request(kind, target, repeats, 1'b0, typed_result);
            end
        end

        // range start outside the clip: elapsed keeps growing past the period
        apply_settings(10, 254, 5, 3);
        send_request(KIND_GOTO_PLAY, 8'd5, 8'd0, 1'b0, typed_result);
        for (int n = 0; n < OVERRUN_TICKS; n++)
            send_request(KIND_TICK, 8'd0, 8'd0, 1'b0, typed_result);
        send_request(KIND_STOP, 8'd0, 8'd0, 1'b0, typed_result);
        send_request(KIND_PLAY, 8'd0, 8'd3, 1'b0, typed_result);
        send_request(KIND_GOTO_STOP, 8'd9, 8'd0, 1'b0, typed_result);

        wait_for_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS animation_frame_sequencer");
        else
            $display("FAIL animation_frame_sequencer");
        $finish;
    end

endmodule
